// ----- sv/saturating_multiply_divide_64_macros.svh -----
// ----------------------------------------------------------------------------
// saturating_multiply_divide_64 assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SATURATING_MULTIPLY_DIVIDE_64_MACROS_SVH
`define SATURATING_MULTIPLY_DIVIDE_64_MACROS_SVH

// same-cycle implication
`define SMD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/smd_pkg.sv -----
// ----------------------------------------------------------------------------
// smd_pkg
// Field width and payload type of the saturating multiply-divide block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smd_pkg;

    localparam int FIELD_W = 64;

    typedef logic [FIELD_W-1:0] field_t;

endpackage

// ----- sv/smd_req_if.sv -----
// ----------------------------------------------------------------------------
// smd_req_if
// Request channel: value, multiplier and divisor with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smd_req_if;
    import smd_pkg::*;

    logic   valid;
    logic   ready;
    field_t value;
    field_t multiplier;
    field_t divisor;

    modport source (output valid, value, multiplier, divisor, input ready);
    modport sink   (input valid, value, multiplier, divisor, output ready);
endinterface

// ----- sv/smd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// smd_rsp_if
// Response channel: scaled result and clamp flag with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smd_rsp_if;
    import smd_pkg::*;

    logic   valid;
    logic   ready;
    field_t scaled;
    logic   clamped;

    modport source (output valid, scaled, clamped, input ready);
    modport sink   (input valid, scaled, clamped, output ready);
endinterface

// ----- sv/smd_div_pipe.sv -----
// ----------------------------------------------------------------------------
// smd_div_pipe
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smd_div_pipe #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_v,
    input  logic [W-1:0] in_m,
    input  logic [W-1:0] in_d,
    input  logic         in_dz,
    output logic         out_valid,
    output logic [W-1:0] out_q,
    output logic [W-1:0] out_r,
    output logic [W-1:0] out_m,
    output logic [W-1:0] out_d,
    output logic         out_dz
);

    logic [W-1:0] vld_reg;
    logic [W-1:0] dz_reg;
    logic [W-1:0] v_reg [W];
    logic [W-1:0] q_reg [W];
    logic [W-1:0] r_reg [W];
    logic [W-1:0] m_reg [W];
    logic [W-1:0] d_reg [W];

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic         vld_in;
        logic         dz_in;
        logic [W-1:0] v_in;
        logic [W-1:0] q_in;
        logic [W-1:0] r_in;
        logic [W-1:0] m_in;
        logic [W-1:0] d_in;
        logic [W-1:0] r_sh;
        logic         take;
        logic [W-1:0] v_next;
        logic [W-1:0] q_next;
        logic [W-1:0] r_next;

        if (s == 0) begin : g_first
            assign vld_in = in_valid;
            assign dz_in  = in_dz;
            assign v_in   = in_v;
            assign q_in   = '0;
            assign r_in   = '0;
            assign m_in   = in_m;
            assign d_in   = in_d;
        end
        else begin : g_rest
            assign vld_in = vld_reg[s-1];
            assign dz_in  = dz_reg[s-1];
            assign v_in   = v_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign r_in   = r_reg[s-1];
            assign m_in   = m_reg[s-1];
            assign d_in   = d_reg[s-1];
        end

        always_comb
        begin
            r_sh   = {r_in[W-2:0], v_in[W-1]};
            take   = r_in[W-1] | (r_sh >= d_in);
            r_next = take ? (r_sh - d_in) : r_sh;
            q_next = {q_in[W-2:0], take};
            v_next = {v_in[W-2:0], 1'b0};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dz_reg[s] <= dz_in;
                v_reg[s]  <= v_next;
                q_reg[s]  <= q_next;
                r_reg[s]  <= r_next;
                m_reg[s]  <= m_in;
                d_reg[s]  <= d_in;
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign out_dz    = dz_reg[W-1];
    assign out_q     = q_reg[W-1];
    assign out_r     = r_reg[W-1];
    assign out_m     = m_reg[W-1];
    assign out_d     = d_reg[W-1];

endmodule

// ----- sv/smd_frac_pipe.sv -----
// ----------------------------------------------------------------------------
// smd_frac_pipe
// Bit-serial floor(rem*m/d), two half-steps per multiplier bit, one per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smd_frac_pipe #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_rem,
    input  logic [W-1:0] in_whole,
    input  logic [W-1:0] in_m,
    input  logic [W-1:0] in_d,
    input  logic         in_dz,
    output logic         out_valid,
    output logic [W-1:0] out_frac,
    output logic [W-1:0] out_whole,
    output logic [W-1:0] out_m,
    output logic         out_dz
);

    localparam int NS = 2 * W;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] dz_reg;
    logic [W-1:0]  frac_reg  [NS];
    logic [W-1:0]  frem_reg  [NS];
    logic [W-1:0]  rem_reg   [NS];
    logic [W-1:0]  whole_reg [NS];
    logic [W-1:0]  m_reg     [NS];
    logic [W-1:0]  d_reg     [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int K = j / 2;

        logic         vld_in;
        logic         dz_in;
        logic [W-1:0] frac_in;
        logic [W-1:0] frem_in;
        logic [W-1:0] rem_in;
        logic [W-1:0] whole_in;
        logic [W-1:0] m_in;
        logic [W-1:0] d_in;
        logic [W:0]   sum;
        logic [W:0]   dif;
        logic         ge;
        logic [W-1:0] frac_next;
        logic [W-1:0] frem_next;

        if (j == 0) begin : g_first
            assign vld_in   = in_valid;
            assign dz_in    = in_dz;
            assign frac_in  = '0;
            assign frem_in  = '0;
            assign rem_in   = in_rem;
            assign whole_in = in_whole;
            assign m_in     = in_m;
            assign d_in     = in_d;
        end
        else begin : g_rest
            assign vld_in   = vld_reg[j-1];
            assign dz_in    = dz_reg[j-1];
            assign frac_in  = frac_reg[j-1];
            assign frem_in  = frem_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign whole_in = whole_reg[j-1];
            assign m_in     = m_reg[j-1];
            assign d_in     = d_reg[j-1];
        end

        if (j % 2 == 0) begin : g_double
            // frem doubles; one fraction bit comes out
            always_comb
            begin
                sum       = {frem_in, 1'b0};
                dif       = sum - {1'b0, d_in};
                ge        = (sum >= {1'b0, d_in});
                frem_next = ge ? dif[W-1:0] : sum[W-1:0];
                frac_next = {frac_in[W-2:0], ge};
            end
        end
        else begin : g_addrem
            // add rem where the multiplier bit is set
            always_comb
            begin
                sum       = {1'b0, frem_in} + {1'b0, rem_in};
                dif       = sum - {1'b0, d_in};
                ge        = m_in[W-1-K] & (sum >= {1'b0, d_in});
                frem_next = !m_in[W-1-K] ? frem_in : (ge ? dif[W-1:0] : sum[W-1:0]);
                frac_next = frac_in + W'(ge);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dz_reg[j]    <= dz_in;
                frac_reg[j]  <= frac_next;
                frem_reg[j]  <= frem_next;
                rem_reg[j]   <= rem_in;
                whole_reg[j] <= whole_in;
                m_reg[j]     <= m_in;
                d_reg[j]     <= d_in;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_dz    = dz_reg[NS-1];
    assign out_frac  = frac_reg[NS-1];
    assign out_whole = whole_reg[NS-1];
    assign out_m     = m_reg[NS-1];

endmodule

// ----- sv/smd_mul_sum.sv -----
// ----------------------------------------------------------------------------
// smd_mul_sum
// whole*m from four half-width partial products, with overflow detect.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smd_mul_sum #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_whole,
    input  logic [W-1:0] in_m,
    input  logic [W-1:0] in_frac,
    input  logic         in_dz,
    output logic         out_valid,
    output logic [W-1:0] out_base,
    output logic         out_ovf,
    output logic [W-1:0] out_frac,
    output logic         out_dz
);

    localparam int HW = (W + 1) / 2;
    localparam int PW = 4 * HW;

    logic [2*HW-1:0] a_ext;
    logic [2*HW-1:0] b_ext;
    logic [2*HW-1:0] ll_next;
    logic [2*HW-1:0] lh_next;
    logic [2*HW-1:0] hl_next;
    logic [2*HW-1:0] hh_next;
    logic [PW-1:0]   prod;

    logic            p1_valid_reg;
    logic            p1_dz_reg;
    logic [W-1:0]    p1_frac_reg;
    logic [2*HW-1:0] ll_reg;
    logic [2*HW-1:0] lh_reg;
    logic [2*HW-1:0] hl_reg;
    logic [2*HW-1:0] hh_reg;

    logic            p2_valid_reg;
    logic            p2_dz_reg;
    logic            p2_ovf_reg;
    logic [W-1:0]    p2_frac_reg;
    logic [W-1:0]    p2_base_reg;

    always_comb
    begin
        a_ext   = (2*HW)'(in_whole);
        b_ext   = (2*HW)'(in_m);
        ll_next = (2*HW)'(a_ext[HW-1:0])    * (2*HW)'(b_ext[HW-1:0]);
        lh_next = (2*HW)'(a_ext[HW-1:0])    * (2*HW)'(b_ext[2*HW-1:HW]);
        hl_next = (2*HW)'(a_ext[2*HW-1:HW]) * (2*HW)'(b_ext[HW-1:0]);
        hh_next = (2*HW)'(a_ext[2*HW-1:HW]) * (2*HW)'(b_ext[2*HW-1:HW]);
    end

    assign prod = PW'(ll_reg) + (PW'(lh_reg) << HW) + (PW'(hl_reg) << HW)
                + (PW'(hh_reg) << (2*HW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_dz_reg   <= in_dz;
            p1_frac_reg <= in_frac;
            ll_reg      <= ll_next;
            lh_reg      <= lh_next;
            hl_reg      <= hl_next;
            hh_reg      <= hh_next;
            p2_dz_reg   <= p1_dz_reg;
            p2_frac_reg <= p1_frac_reg;
            p2_base_reg <= prod[W-1:0];
            p2_ovf_reg  <= |prod[PW-1:W];
        end
    end

    assign out_valid = p2_valid_reg;
    assign out_base  = p2_base_reg;
    assign out_ovf   = p2_ovf_reg;
    assign out_frac  = p2_frac_reg;
    assign out_dz    = p2_dz_reg;

endmodule

// ----- sv/saturating_multiply_divide_64.sv -----
// ----------------------------------------------------------------------------
// saturating_multiply_divide_64
// Pipelined floor(value*multiplier/divisor), clamped to all ones and flagged.
// ----------------------------------------------------------------------------
//  channel  role   fields
//  req      sink   value, multiplier, divisor
//  rsp      source scaled, clamped
//
//  One transaction per cycle while the skid register is empty; pipeline of DATA_WIDTH
//  divider stages, 2*DATA_WIDTH fraction half-steps, two multiply stages, one output stage.
//  Reset clears the stage valid bits and the skid valid bit only.
//  A stalled result moves into the skid register; the pipeline then holds
//  (req.ready low) until the skid register drains.
`timescale 1ns / 1ps

module saturating_multiply_divide_64 #(
    parameter int DATA_WIDTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    smd_req_if.sink   req,
    smd_rsp_if.source rsp
);
    import smd_pkg::*;

    localparam int W = DATA_WIDTH;

    logic         en;
    logic [W-1:0] v_in;
    logic [W-1:0] m_in;
    logic [W-1:0] d_in;

    logic         dv_valid;
    logic [W-1:0] dv_q;
    logic [W-1:0] dv_r;
    logic [W-1:0] dv_m;
    logic [W-1:0] dv_d;
    logic         dv_dz;

    logic         fr_valid;
    logic [W-1:0] fr_frac;
    logic [W-1:0] fr_whole;
    logic [W-1:0] fr_m;
    logic         fr_dz;

    logic         ms_valid;
    logic [W-1:0] ms_base;
    logic         ms_ovf;
    logic [W-1:0] ms_frac;
    logic         ms_dz;

    logic [W:0]   total;
    logic         clamp_next;
    logic [W-1:0] scaled_next;

    logic         fin_valid_reg;
    logic [W-1:0] fin_scaled_reg;
    logic         fin_clamped_reg;
    logic         skid_valid_reg;
    logic [W-1:0] skid_scaled_reg;
    logic         skid_clamped_reg;

    assign en        = !skid_valid_reg;
    assign req.ready = en;
    assign v_in      = req.value[W-1:0];
    assign m_in      = req.multiplier[W-1:0];
    assign d_in      = req.divisor[W-1:0];

    smd_div_pipe #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .in_v      (v_in),
        .in_m      (m_in),
        .in_d      (d_in),
        .in_dz     (d_in == '0),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_r     (dv_r),
        .out_m     (dv_m),
        .out_d     (dv_d),
        .out_dz    (dv_dz)
    );

    smd_frac_pipe #(.W(W)) u_frac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_rem    (dv_r),
        .in_whole  (dv_q),
        .in_m      (dv_m),
        .in_d      (dv_d),
        .in_dz     (dv_dz),
        .out_valid (fr_valid),
        .out_frac  (fr_frac),
        .out_whole (fr_whole),
        .out_m     (fr_m),
        .out_dz    (fr_dz)
    );

    smd_mul_sum #(.W(W)) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_whole  (fr_whole),
        .in_m      (fr_m),
        .in_frac   (fr_frac),
        .in_dz     (fr_dz),
        .out_valid (ms_valid),
        .out_base  (ms_base),
        .out_ovf   (ms_ovf),
        .out_frac  (ms_frac),
        .out_dz    (ms_dz)
    );

    always_comb
    begin
        total       = {1'b0, ms_base} + {1'b0, ms_frac};
        clamp_next  = ms_dz | ms_ovf | total[W];
        scaled_next = clamp_next ? {W{1'b1}} : total[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                fin_valid_reg <= ms_valid;
            end
            if (skid_valid_reg)
            begin
                if (rsp.ready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (fin_valid_reg && !rsp.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_scaled_reg  <= scaled_next;
            fin_clamped_reg <= clamp_next;
        end
        if (!skid_valid_reg && fin_valid_reg && !rsp.ready)
        begin
            skid_scaled_reg  <= fin_scaled_reg;
            skid_clamped_reg <= fin_clamped_reg;
        end
    end

    assign rsp.valid   = skid_valid_reg | fin_valid_reg;
    assign rsp.scaled  = FIELD_W'(skid_valid_reg ? skid_scaled_reg : fin_scaled_reg);
    assign rsp.clamped = skid_valid_reg ? skid_clamped_reg : fin_clamped_reg;

endmodule

// ----- sv/smd_checker.sv -----
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks of the multiply-divide block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "saturating_multiply_divide_64_macros.svh"

module smd_checker #(
    parameter int DATA_WIDTH = 64
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input smd_pkg::field_t rsp_scaled,
    input logic           rsp_clamped
);
    import smd_pkg::*;

    localparam field_t ONES = FIELD_W'({DATA_WIDTH{1'b1}});

    logic unused_req_valid;
    assign unused_req_valid = req_valid;

    `SMD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_scaled) && $stable(rsp_clamped), "response transaction changed while stalled")
    `SMD_ASSERT_IMPLY(a_clamp_ones, rsp_valid && rsp_clamped, rsp_scaled == ONES, "clamped result is not all ones")
    `SMD_ASSERT_IMPLY(a_width, rsp_valid, (rsp_scaled & ~ONES) == '0, "result bits above operand width")
    `SMD_ASSERT_IMPLY(a_stall_cause, $fell(req_ready), $past(rsp_valid && !rsp_ready), "ready dropped without a stalled response")

endmodule

bind saturating_multiply_divide_64 smd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_smd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_scaled  (rsp.scaled),
    .rsp_clamped (rsp.clamped)
);

// ----- dv/saturating_multiply_divide_64_tb.sv -----
// ----------------------------------------------------------------------------
// saturating_multiply_divide_64_tb
// Drives scaling requests with random idling on both channels, predicts
// floor(value*multiplier/divisor) with clamping, and checks each response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module saturating_multiply_divide_64_tb;
    import smd_pkg::*;

    localparam int W         = FIELD_W;
    localparam int LATENCY   = 3 * W + 3;
    localparam int CYCLE_MAX = 400000;

    typedef struct packed {
        field_t scaled;
        logic   clamped;
    } scale_res_t;

    logic clk;
    logic rst_n;

    smd_req_if req ();
    smd_rsp_if rsp ();

    saturating_multiply_divide_64 #(.DATA_WIDTH(W)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    scale_res_t scaled_q[$];
    int         mismatches;
    int         cycles;
    bit         rsp_stall_on;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic scale_res_t predict_scale(field_t v, field_t m, field_t d);
        scale_res_t r;
        logic [2*W:0] prod;
        field_t whole;
        field_t rem;
        field_t frac;
        field_t frem;
        field_t base;
        logic [W:0] sum;
        r.scaled  = '1;
        r.clamped = 1'b1;
        if (d == '0)
            return r;
        if (v == '0 || m == '0)
        begin
            r.scaled  = '0;
            r.clamped = 1'b0;
            return r;
        end
        whole = v / d;
        rem   = v % d;
        prod  = whole * m;
        if (prod[2*W:W] != '0)
            return r;
        base = prod[W-1:0];
        frac = '0;
        frem = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            frac = frac << 1;
            if (frem >= d - frem)
            begin
                frem = frem - (d - frem);
                frac = frac + 1;
            end
            else
                frem = frem + frem;
            if (m[i])
            begin
                if (frem >= d - rem)
                begin
                    frem = frem - (d - rem);
                    frac = frac + 1;
                end
                else
                    frem = frem + rem;
            end
        end
        sum = {1'b0, base} + {1'b0, frac};
        if (sum[W])
            return r;
        r.scaled  = sum[W-1:0];
        r.clamped = 1'b0;
        return r;
    endfunction

    function automatic field_t rand_field();
        field_t f;
        f = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: f = f >> $urandom_range(0, W - 1);
            1: f = f >> $urandom_range(32, W - 1);
            2: f = '1 >> $urandom_range(0, W - 1);
            3: f = field_t'(1) << $urandom_range(0, W - 1);
            default: ;
        endcase
        return f;
    endfunction

    // response side: random stall bursts, checking against the oldest prediction
    always @(posedge clk)
    begin
        scale_res_t exp_r;
        cycles <= cycles + 1;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (scaled_q.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected transaction scaled=%h clamped=%b",
                             rsp.scaled, rsp.clamped);
            end
            else
            begin
                exp_r = scaled_q.pop_front();
                if (rsp.scaled !== exp_r.scaled || rsp.clamped !== exp_r.clamped)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch exp scaled=%h clamped=%b got scaled=%h clamped=%b",
                                 exp_r.scaled, exp_r.clamped, rsp.scaled, rsp.clamped);
                end
            end
        end
    end

    initial
    begin
        int n;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_stall_on && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 12);
                rsp.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    initial
    begin
        @(posedge clk);
        while (cycles < CYCLE_MAX)
            @(posedge clk);
        $display("saturating_multiply_divide_64_tb: FAIL");
        $finish;
    end

    task automatic send_scale(field_t v, field_t m, field_t d, bit idle);
        if (idle && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.value      <= v;
        req.multiplier <= m;
        req.divisor    <= d;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        scaled_q.push_back(predict_scale(v, m, d));
    endtask

    task automatic test_special_cases();
        field_t ones;
        ones = '1;
        send_scale(0, 0, 0, 1'b1);
        send_scale(ones, ones, 0, 1'b1);
        send_scale(5, 7, 0, 1'b1);
        send_scale(0, ones, 3, 1'b1);
        send_scale(ones, 0, 3, 1'b1);
        send_scale(ones, ones, ones, 1'b1);
        send_scale(ones, 2, 1, 1'b1);
        send_scale(ones, ones, 2, 1'b1);
        send_scale(ones - 1, ones, ones - 1, 1'b1);
        send_scale(ones, 1, 1, 1'b1);
        send_scale(ones, 3, 3, 1'b1);
        send_scale(ones - 1, 3, 2, 1'b1);
        send_scale(ones, ones - 1, ones, 1'b1);
        send_scale(64'h8000_0000_0000_0000, 2, 1, 1'b1);
        send_scale(64'h8000_0000_0000_0000, 3, 2, 1'b1);
        send_scale(7, 3, 10, 1'b1);
        send_scale(1, 1, ones, 1'b1);
        send_scale(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, ones, 1'b1);
        send_scale(ones, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 1'b1);
    endtask

    task automatic test_random(int count, bit idle);
        field_t v;
        field_t m;
        field_t d;
        for (int i = 0; i < count; i++)
        begin
            v = rand_field();
            m = rand_field();
            d = rand_field();
            if ($urandom_range(0, 31) == 0)
                d = '0;
            send_scale(v, m, d, idle);
        end
    endtask

    initial
    begin
        mismatches   = 0;
        cycles       = 0;
        rsp_stall_on = 1'b1;
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.value      <= '0;
        req.multiplier <= '0;
        req.divisor    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_random(1000, 1'b1);
        rsp_stall_on = 1'b0;
        test_random(200, 1'b0);
        req.valid <= 1'b0;
        while (scaled_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && scaled_q.size() == 0)
            $display("saturating_multiply_divide_64_tb: PASS");
        else
            $display("saturating_multiply_divide_64_tb: FAIL");
        $finish;
    end

endmodule
